@@ hdl/u16m2u8_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package u16m2u8_pkg;

   localparam int unsigned RUN_LEN_W = 5;

   localparam logic [15:0] CU_NUL       = 16'h0000;
   localparam logic [15:0] CU_TAB       = 16'h0009;
   localparam logic [15:0] CU_NEWLINE   = 16'h000A;
   localparam logic [15:0] CU_SPACE     = 16'h0020;
   localparam logic [15:0] CU_QUOTE     = 16'h0022;
   localparam logic [15:0] CU_BACKSLASH = 16'h005C;
   localparam logic [15:0] CU_ASCII_END = 16'h0080;
   localparam logic [15:0] CU_TAG_OPEN  = 16'h007B;
   localparam logic [15:0] CU_TAG_CLOSE = 16'h007D;
   localparam logic [15:0] CU_NBSP      = 16'h00A0;
   localparam logic [15:0] CU_LAQUO     = 16'h00AB;
   localparam logic [15:0] CU_SHY       = 16'h00AD;
   localparam logic [15:0] CU_RAQUO     = 16'h00BB;
   localparam logic [15:0] CU_DASH_LO   = 16'h2010;
   localparam logic [15:0] CU_DASH_HI   = 16'h2015;
   localparam logic [15:0] CU_SQUOTE_LO = 16'h2018;
   localparam logic [15:0] CU_SQUOTE_HI = 16'h201B;
   localparam logic [15:0] CU_DQUOTE_LO = 16'h201C;
   localparam logic [15:0] CU_DQUOTE_HI = 16'h201F;
   localparam logic [15:0] CU_BULLET_LO = 16'h2020;
   localparam logic [15:0] CU_BULLET_HI = 16'h2027;
   localparam logic [15:0] CU_PRIME_LO  = 16'h2030;
   localparam logic [15:0] CU_PRIME_HI  = 16'h2033;

   localparam logic [7:0] BYTE_SPACE     = 8'h20;
   localparam logic [7:0] BYTE_DQUOTE    = 8'h22;
   localparam logic [7:0] BYTE_SQUOTE    = 8'h27;
   localparam logic [7:0] BYTE_STAR      = 8'h2A;
   localparam logic [7:0] BYTE_DASH      = 8'h2D;
   localparam logic [7:0] BYTE_X         = 8'h78;
   localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;

   localparam logic [RUN_LEN_W-1:0] QUOTE_REF_LEN = 5'd19;
   localparam logic [RUN_LEN_W-1:0] NEWLINE_LEN   = 5'd6;
   localparam logic [RUN_LEN_W-1:0] TAB_LEN       = 5'd5;

   typedef enum logic [1:0] {
      RUN_CHARS,
      RUN_QUOTE_REF,
      RUN_NEWLINE,
      RUN_TAB
   } run_kind_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        body_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_word_type;

   // The escaped quote expands to [i][ref]"[/ref][/i].
   function automatic logic [7:0] quote_ref_byte(input logic [RUN_LEN_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = "[";
         5'd1:    b = "i";
         5'd2:    b = "]";
         5'd3:    b = "[";
         5'd4:    b = "r";
         5'd5:    b = "e";
         5'd6:    b = "f";
         5'd7:    b = "]";
         5'd8:    b = BYTE_DQUOTE;
         5'd9:    b = "[";
         5'd10:   b = "/";
         5'd11:   b = "r";
         5'd12:   b = "e";
         5'd13:   b = "f";
         5'd14:   b = "]";
         5'd15:   b = "[";
         5'd16:   b = "/";
         5'd17:   b = "i";
         5'd18:   b = "]";
         default: b = "]";
      endcase
      return b;
   endfunction

   // A newline expands to newline, tab, [m1].
   function automatic logic [7:0] newline_byte(input logic [RUN_LEN_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = 8'h0A;
         5'd1:    b = 8'h09;
         5'd2:    b = "[";
         5'd3:    b = "m";
         5'd4:    b = "1";
         default: b = "]";
      endcase
      return b;
   endfunction

   // A tab expands to tab, [m2].
   function automatic logic [7:0] tab_byte(input logic [RUN_LEN_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = 8'h09;
         5'd1:    b = "[";
         5'd2:    b = "m";
         5'd3:    b = "2";
         default: b = "]";
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ hdl/utf16_markup_to_utf8_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                              Word
// input     req_valid, req_stall, req_word     code_unit[15:0], body_end
// result    rsp_valid, rsp_stall, rsp_word     out_byte[7:0], run_last
//
// A code unit is decoded in the cycle it is accepted into a run register that
// holds its zero to nineteen output bytes; one byte per cycle moves from there
// into the output register while the result side does not stall. Units giving
// one byte or none stream back to back; a unit giving more bytes stalls the
// input until its last byte has moved into the output register.
// The next unit is taken in the same cycle as the last byte of the current run.
// Reset clears the filter state and both valid flags. A stall on the result side
// backs up into req_stall once the run register is occupied.

module utf16_markup_to_utf8_filter
   import u16m2u8_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output rsp_word_type      rsp_word
);

   logic                 in_tag_ff, in_tag_in;
   logic                 escape_ff, escape_in;
   logic                 halted_ff, halted_in;

   logic                 run_valid_ff;
   run_kind_type         run_kind_ff, run_kind_in;
   logic [2:0][7:0]      run_bytes_ff, run_bytes_in;
   logic [RUN_LEN_W-1:0] run_len_ff, run_len_in;
   logic [RUN_LEN_W-1:0] run_idx_ff;

   logic                 rsp_valid_ff;
   rsp_word_type         rsp_word_ff;

   logic                 out_load;
   logic                 run_done;
   logic                 req_accept;
   logic [7:0]           cur_byte;

   logic [15:0]          cu;
   logic [2:0][7:0]      enc_bytes;
   logic [RUN_LEN_W-1:0] enc_len;

   assign out_load   = run_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign run_done   = out_load && (run_idx_ff == run_len_ff - 5'd1);
   assign req_stall  = run_valid_ff && !run_done;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      case (run_kind_ff)
         RUN_QUOTE_REF: cur_byte = quote_ref_byte(run_idx_ff);
         RUN_NEWLINE:   cur_byte = newline_byte(run_idx_ff);
         RUN_TAB:       cur_byte = tab_byte(run_idx_ff);
         default:       cur_byte = run_bytes_ff[run_idx_ff[1:0]];
      endcase
   end

   // Plain UTF-8 of the unit; surrogates come out as three bytes each.
   assign cu = req_word.code_unit;

   always_comb begin
      enc_bytes = '0;
      if (cu < 16'h0080) begin
         enc_bytes[0] = cu[7:0];
         enc_len      = 5'd1;
      end else if (cu < 16'h0800) begin
         enc_bytes[0] = {3'b110, cu[10:6]};
         enc_bytes[1] = {2'b10, cu[5:0]};
         enc_len      = 5'd2;
      end else begin
         enc_bytes[0] = {4'b1110, cu[15:12]};
         enc_bytes[1] = {2'b10, cu[11:6]};
         enc_bytes[2] = {2'b10, cu[5:0]};
         enc_len      = 5'd3;
      end
   end

   always_comb begin
      in_tag_in    = in_tag_ff;
      escape_in    = escape_ff;
      halted_in    = halted_ff;
      run_kind_in  = RUN_CHARS;
      run_bytes_in = '0;
      run_len_in   = '0;
      if (halted_ff) begin
         run_len_in = '0;
      end else if (escape_ff) begin
         escape_in = 1'b0;
         if (cu == CU_QUOTE) begin
            run_kind_in = RUN_QUOTE_REF;
            run_len_in  = QUOTE_REF_LEN;
         end else begin
            run_bytes_in = enc_bytes;
            run_len_in   = enc_len;
         end
      end else if (cu == CU_NUL) begin
         halted_in = 1'b1;
      end else if (cu == CU_NEWLINE) begin
         run_kind_in = RUN_NEWLINE;
         run_len_in  = NEWLINE_LEN;
      end else if (cu == CU_TAB) begin
         run_kind_in = RUN_TAB;
         run_len_in  = TAB_LEN;
      end else if (cu < CU_SPACE) begin
         run_bytes_in[0] = BYTE_SPACE;
         run_len_in      = 5'd1;
      end else if (cu == CU_BACKSLASH && !req_word.body_end) begin
         escape_in = 1'b1;
      end else if (cu < CU_ASCII_END) begin
         if (cu == CU_TAG_OPEN) begin
            in_tag_in = 1'b1;
         end else if (in_tag_ff) begin
            if (cu == CU_TAG_CLOSE) begin
               in_tag_in = 1'b0;
            end
         end else begin
            run_bytes_in[0] = cu[7:0];
            run_len_in      = 5'd1;
         end
      end else if (cu inside {[CU_DASH_LO:CU_DASH_HI], CU_SHY}) begin
         run_bytes_in[0] = BYTE_DASH;
         run_len_in      = 5'd1;
      end else if (cu inside {[CU_SQUOTE_LO:CU_SQUOTE_HI]}) begin
         run_bytes_in[0] = BYTE_SQUOTE;
         run_len_in      = 5'd1;
      end else if (cu inside {[CU_DQUOTE_LO:CU_DQUOTE_HI], CU_LAQUO, CU_RAQUO}) begin
         run_bytes_in[0] = BYTE_DQUOTE;
         run_len_in      = 5'd1;
      end else if (cu inside {[CU_BULLET_LO:CU_BULLET_HI]}) begin
         run_bytes_in[0] = BYTE_STAR;
         run_len_in      = 5'd1;
      end else if (cu inside {[CU_PRIME_LO:CU_PRIME_HI]}) begin
         run_bytes_in[0] = BYTE_X;
         run_len_in      = 5'd1;
      end else if (cu == CU_NBSP) begin
         run_bytes_in[0] = BYTE_SPACE;
         run_len_in      = 5'd1;
      end else begin
         run_bytes_in = enc_bytes;
         run_len_in   = enc_len;
      end
      if (req_word.body_end) begin
         in_tag_in = 1'b0;
         escape_in = 1'b0;
         halted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff    <= 1'b0;
         escape_ff    <= 1'b0;
         halted_ff    <= 1'b0;
         run_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= run_valid_ff;
         end
         if (out_load) begin
            rsp_word_ff.out_byte <= cur_byte;
            rsp_word_ff.run_last <= run_done;
         end
         if (req_accept) begin
            in_tag_ff    <= in_tag_in;
            escape_ff    <= escape_in;
            halted_ff    <= halted_in;
            run_valid_ff <= (run_len_in != '0);
            run_kind_ff  <= run_kind_in;
            run_bytes_ff <= run_bytes_in;
            run_len_ff   <= run_len_in;
            run_idx_ff   <= '0;
         end else begin
            if (run_done) begin
               run_valid_ff <= 1'b0;
            end
            if (out_load) begin
               run_idx_ff <= run_idx_ff + 5'd1;
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ bench/utf8_byte_checker.sv @@
`timescale 1ns / 1ps

module utf8_byte_checker
   import u16m2u8_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   input  wire          req_stall,
   input  req_word_type req_word,
   input  wire          rsp_valid,
   input  wire          rsp_stall,
   input  rsp_word_type rsp_word,
   output int           error_count,
   output int           pending_count,
   output int           byte_count
);

   rsp_word_type expected_bytes[$];
   rsp_word_type wanted;
   logic         in_tag;
   logic         escape_pending;
   logic         halted;
   int           errors;
   int           bytes_seen;

   initial begin
      error_count   = 0;
      pending_count = 0;
      byte_count    = 0;
      errors        = 0;
      bytes_seen    = 0;
   end

   function automatic void push_byte(input logic [7:0] b);
      rsp_word_type w;
      w.out_byte = b;
      w.run_last = 1'b0;
      expected_bytes.push_back(w);
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i]);
      end
   endfunction

   function automatic void push_utf8(input logic [15:0] cp);
      if (cp < 16'h0080) begin
         push_byte(cp[7:0]);
      end else if (cp < 16'h0800) begin
         push_byte({3'b110, cp[10:6]});
         push_byte({2'b10, cp[5:0]});
      end else begin
         push_byte({4'b1110, cp[15:12]});
         push_byte({2'b10, cp[11:6]});
         push_byte({2'b10, cp[5:0]});
      end
   endfunction

   // Appends the bytes one code unit produces and marks the last of them.
   function automatic void predict_unit(input req_word_type w);
      int           start;
      logic [15:0]  u;
      rsp_word_type tail;
      start = expected_bytes.size();
      u = w.code_unit;
      if (halted) begin
      end else if (escape_pending) begin
         escape_pending = 1'b0;
         if (u == CU_QUOTE) begin
            push_text("[i][ref]\"[/ref][/i]");
         end else begin
            push_utf8(u);
         end
      end else if (u == CU_NUL) begin
         halted = 1'b1;
      end else if (u == CU_NEWLINE) begin
         push_text("\n\t[m1]");
      end else if (u == CU_TAB) begin
         push_text("\t[m2]");
      end else if (u < CU_SPACE) begin
         push_byte(BYTE_SPACE);
      end else if (u == CU_BACKSLASH && !w.body_end) begin
         escape_pending = 1'b1;
      end else if (u < CU_ASCII_END) begin
         if (u == CU_TAG_OPEN) begin
            in_tag = 1'b1;
         end else if (in_tag) begin
            if (u == CU_TAG_CLOSE) begin
               in_tag = 1'b0;
            end
         end else begin
            push_byte(u[7:0]);
         end
      end else if ((u >= CU_DASH_LO && u <= CU_DASH_HI) || u == CU_SHY) begin
         push_byte(BYTE_DASH);
      end else if (u >= CU_SQUOTE_LO && u <= CU_SQUOTE_HI) begin
         push_byte(BYTE_SQUOTE);
      end else if ((u >= CU_DQUOTE_LO && u <= CU_DQUOTE_HI) || u == CU_LAQUO
                   || u == CU_RAQUO) begin
         push_byte(BYTE_DQUOTE);
      end else if (u >= CU_BULLET_LO && u <= CU_BULLET_HI) begin
         push_byte(BYTE_STAR);
      end else if (u >= CU_PRIME_LO && u <= CU_PRIME_HI) begin
         push_byte(BYTE_X);
      end else if (u == CU_NBSP) begin
         push_byte(BYTE_SPACE);
      end else begin
         push_utf8(u);
      end
      if (expected_bytes.size() > start) begin
         tail = expected_bytes.pop_back();
         tail.run_last = 1'b1;
         expected_bytes.push_back(tail);
      end
      if (w.body_end) begin
         in_tag         = 1'b0;
         escape_pending = 1'b0;
         halted         = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         in_tag         = 1'b0;
         escape_pending = 1'b0;
         halted         = 1'b0;
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_unit(req_word);
         end
         if (rsp_valid && !rsp_stall) begin
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
               if (errors < 10) begin
                  $display("ERROR at %0t: unexpected word, out_byte %h run_last %b",
                           $realtime, rsp_word.out_byte, rsp_word.run_last);
               end
               errors++;
            end else begin
               wanted = expected_bytes.pop_front();
               if (rsp_word.out_byte !== wanted.out_byte
                   || rsp_word.run_last !== wanted.run_last) begin
                  if (errors < 10) begin
                     $display("ERROR at %0t: expected out_byte %h run_last %b, got %h %b",
                              $realtime, wanted.out_byte, wanted.run_last,
                              rsp_word.out_byte, rsp_word.run_last);
                  end
                  errors++;
               end
            end
         end
      end
      error_count   <= errors;
      pending_count <= expected_bytes.size();
      byte_count    <= bytes_seen;
   end

endmodule

@@ bench/utf16_markup_to_utf8_filter_test.sv @@
`timescale 1ns / 1ps

module utf16_markup_to_utf8_filter_test
   import u16m2u8_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASE_UNITS    = 22;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int error_count;
   int pending_count;
   int byte_count;
   int units_sent   = 0;
   int send_idle    = 0;
   int stall_rate   = 0;
   int quiet_cycles = 0;

   req_word_type directed_words[28] = '{
      {16'h0041, 1'b0}, {CU_NEWLINE, 1'b0}, {CU_TAB, 1'b0}, {16'h001F, 1'b0},
      {16'h0080, 1'b0}, {16'h07FF, 1'b0}, {16'hD800, 1'b0}, {16'hFFFF, 1'b0},
      {CU_DASH_LO, 1'b0}, {CU_SQUOTE_HI, 1'b0}, {CU_DQUOTE_LO, 1'b0},
      {CU_BULLET_HI, 1'b0}, {CU_PRIME_HI, 1'b0}, {CU_LAQUO, 1'b0}, {CU_NBSP, 1'b0},
      {CU_SHY, 1'b0}, {CU_TAG_OPEN, 1'b0}, {16'h0061, 1'b0}, {16'h00E9, 1'b0},
      {CU_BACKSLASH, 1'b0}, {CU_QUOTE, 1'b0}, {CU_TAG_CLOSE, 1'b0},
      {CU_BACKSLASH, 1'b0}, {CU_NUL, 1'b0}, {CU_BACKSLASH, 1'b1},
      {CU_NUL, 1'b0}, {16'h0041, 1'b0}, {16'h0041, 1'b1}
   };

   utf16_markup_to_utf8_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   utf8_byte_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .error_count   (error_count),
      .pending_count (pending_count),
      .byte_count    (byte_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_rate);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer.", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_unit(input req_word_type w);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      units_sent++;
   endtask

   task automatic send_random_unit();
      logic [15:0] cu;
      logic        is_end;
      int          pick;
      pick   = $urandom_range(99);
      is_end = ($urandom_range(11) == 0);
      if (pick < 30) begin
         cu = 16'($urandom_range(16'h007E, 16'h0020));
      end else if (pick < 36) begin
         cu = pick[0] ? CU_TAG_OPEN : CU_TAG_CLOSE;
      end else if (pick < 45) begin
         send_unit({CU_BACKSLASH, 1'b0});
         case ($urandom_range(3))
            0:       cu = CU_QUOTE;
            1:       cu = 16'($urandom_range(31));
            2:       cu = CU_BACKSLASH;
            default: cu = 16'($urandom);
         endcase
      end else if (pick < 52) begin
         cu = 16'($urandom_range(16'h001F, 16'h0001));
      end else if (pick < 66) begin
         cu = 16'($urandom_range(CU_PRIME_HI, CU_DASH_LO));
      end else if (pick < 72) begin
         case ($urandom_range(3))
            0:       cu = CU_NBSP;
            1:       cu = CU_LAQUO;
            2:       cu = CU_SHY;
            default: cu = CU_RAQUO;
         endcase
      end else if (pick < 82) begin
         cu = 16'($urandom_range(16'h07FF, 16'h0080));
      end else if (pick < 98) begin
         cu = 16'($urandom);
      end else begin
         cu = CU_NUL;
      end
      send_unit({cu, is_end});
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle  = 20;
      stall_rate = 60;
      foreach (directed_words[i]) begin
         send_unit(directed_words[i]);
      end
      for (int phase = 0; phase < 3; phase++) begin
         send_idle  = (phase == 0) ? 20 : (phase == 1) ? 60 : 0;
         stall_rate = (phase == 0) ? 60 : (phase == 1) ? 20 : 0;
         repeat (PHASE_UNITS) send_random_unit();
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d code units (directed edge cases, then random bodies) under three",
               units_sent);
      $display("flow-control mixes, and checked %0d output bytes.", byte_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/u16m2u8_pkg.sv
hdl/utf16_markup_to_utf8_filter.sv
bench/utf8_byte_checker.sv
bench/utf16_markup_to_utf8_filter_test.sv
